>>> hdl/pcbd_pkg.sv
// Package for the prefix-code byte decompressor.
// Holds the shared field widths, register indexes, reset values and the result beat type.
// No dependencies.
package pcbd_pkg;

  localparam int BYTE_W    = 8;
  localparam int DICT_W    = 64;
  localparam int FLEN_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [FLEN_W-1:0] FRAME_LENGTH_RESET = 16'd8;

  localparam logic [CFG_IDX_W-1:0] REG_DICTIONARY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 1'b1;

  localparam int IN_DEPTH_DEFAULT  = 2;
  localparam int OUT_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              last;
  } result_t;

endpackage

>>> hdl/prefix_code_byte_decompressor_core.sv
// Top level of the prefix-code byte decompressor.
// Depends on pcbd_pkg, pcbd_fifo and pcbd_back.

// Compressed bytes enter through a push/full queue and decoded bytes leave
// through an empty/pop queue; both sides may stall freely. Each input byte
// is appended, most significant bit first, to a 17-bit buffer, and the
// decoder then takes one prefix symbol per cycle while the result queue has
// room: 0 is a zero byte, 11 and eight bits is a literal, 101 and three
// bits is a dictionary entry, 100 and three bits is a byte with that single
// bit set. Each input byte is first loaded into the buffer and then yields
// at most eight decoded bytes, one per symbol; the decoder takes no new
// input byte until it is through with the current one. The final result
// beat of each input byte carries last. After frame_length decoded bytes
// the beat carries frame_end and every pending bit, including the rest of
// the current input byte, is discarded.
// Configuration: index 0 writes the 64-bit dictionary (entry i in bits
// 8i+7 down to 8i), index 1 writes frame_length from the low 16 data bits.
// Writes take effect at once and are meant to happen while the block is idle.
module prefix_code_byte_decompressor_core
  import pcbd_pkg::*;
#(
  parameter int IN_DEPTH  = IN_DEPTH_DEFAULT,
  parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [BYTE_W-1:0]    in_byte,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_frame_end,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DICT_W-1:0]    cfg_data
);

  logic [DICT_W-1:0] dictionary_r;
  logic [FLEN_W-1:0] frame_length_r;

  logic              q_empty;
  logic              q_pop;
  logic [BYTE_W-1:0] q_byte;
  logic              res_full;
  logic              res_push;
  result_t           res;
  result_t           out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dictionary_r   <= '0;
      frame_length_r <= FRAME_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DICTIONARY:   dictionary_r   <= cfg_data;
        REG_FRAME_LENGTH: frame_length_r <= cfg_data[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: the input queue decouples the producer from the decoder.
  pcbd_fifo #(
    .WIDTH (BYTE_W),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (in_byte),
    .full      (in_full),
    .pop       (q_pop),
    .pop_data  (q_byte),
    .empty     (q_empty)
  );

  // Back end: bit buffer and symbol decoder.
  pcbd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_byte       (q_byte),
    .q_pop        (q_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res),
    .dictionary   (dictionary_r),
    .frame_length (frame_length_r)
  );

  // Result queue: finished beats wait here while the decoder keeps going.
  pcbd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_res),
    .empty     (out_empty)
  );

  assign out_byte      = out_res.out_byte;
  assign out_frame_end = out_res.frame_end;
  assign out_last      = out_res.last;

  // The decoder must never push a beat into a full result queue.
  a_no_res_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("decoder pushed into a full result queue");

  // A frame end always closes the beats of its input byte.
  a_frame_end_last : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_end) |-> out_last)
    else $error("frame_end beat without last");

  // The decoder takes a byte from the input queue only when one is waiting.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("input queue popped while empty");

  // Reset leaves both queues empty.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> (!in_full && out_empty))
    else $error("queues not empty after reset");

endmodule

>>> hdl/pcbd_fifo.sv
// Small register queue used on both sides of the decoder.
// Generic width and depth; depends on nothing else.
module pcbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/pcbd_back.sv
// Decoder back end: bit buffer and one-symbol-per-cycle prefix decoder, stalled while the result queue is full.
// Depends on pcbd_pkg for widths and the result beat type.
module pcbd_back
  import pcbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [BYTE_W-1:0] q_byte,
  output logic              q_pop,
  input  logic              res_full,
  output logic              res_push,
  output result_t           res,
  input  logic [DICT_W-1:0] dictionary,
  input  logic [FLEN_W-1:0] frame_length
);

  // The buffer is kept left aligned: the oldest pending bit sits in bit 16.
  logic [16:0]       buf_r, buf_nxt;
  logic [4:0]        held_r, held_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [FLEN_W-1:0] bytes_r, bytes_nxt;
  logic              busy_r, busy_nxt;

  logic [16:0]       base_buf;
  logic [4:0]        base_held;
  logic [3:0]        len, nxt_len;
  logic [16:0]       shifted_buf;
  logic [4:0]        shifted_held;
  logic [FLEN_W-1:0] bytes_inc;
  logic              done;
  logic [2:0]        idx;
  logic [BYTE_W-1:0] val;

  // Length of the complete symbol at the head of the buffer, zero if incomplete.
  function automatic logic [3:0] sym_len(logic [16:0] a, logic [4:0] h);
    logic [3:0] l;
    l = 4'd0;
    if (h != 5'd0) begin
      if (!a[16]) begin
        l = 4'd1;
      end else if (h >= 5'd2) begin
        if (a[15]) begin
          l = (h >= 5'd10) ? 4'd10 : 4'd0;
        end else begin
          l = (h >= 5'd6) ? 4'd6 : 4'd0;
        end
      end
    end
    return l;
  endfunction

  assign len          = sym_len(buf_r, held_r);
  assign shifted_buf  = buf_r << len;
  assign shifted_held = held_r - 5'(len);
  assign nxt_len      = sym_len(shifted_buf, shifted_held);
  assign bytes_inc    = bytes_r + 1'b1;
  assign done         = (bytes_inc == frame_length);
  assign idx          = buf_r[13:11];

  always_comb begin
    if (!buf_r[16]) begin
      val = '0;
    end else if (buf_r[15]) begin
      val = buf_r[14:7];
    end else if (buf_r[14]) begin
      val = dictionary[{idx, 3'b000} +: BYTE_W];
    end else begin
      val = BYTE_W'(1) << idx;
    end
  end

  // A buffer left with more than nine bits is dropped before the next byte.
  assign base_buf  = (held_r > 5'd9) ? '0 : buf_r;
  assign base_held = (held_r > 5'd9) ? '0 : held_r;

  assign q_pop         = !busy_r && !q_empty;
  assign res_push      = busy_r && !res_full && (len != 4'd0);
  assign res.out_byte  = val;
  assign res.frame_end = done;
  assign res.last      = done || (cnt_r == 3'd7) || (nxt_len == 4'd0);

  always_comb begin
    buf_nxt   = buf_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    busy_nxt  = busy_r;
    if (q_pop) begin
      buf_nxt  = base_buf | ({9'd0, q_byte} << (4'd9 - base_held[3:0]));
      held_nxt = base_held + 5'd8;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (res_push) begin
      cnt_nxt  = cnt_r + 1'b1;
      busy_nxt = !res.last;
      if (done) begin
        buf_nxt   = '0;
        held_nxt  = '0;
        bytes_nxt = '0;
      end else begin
        buf_nxt   = shifted_buf;
        held_nxt  = shifted_held;
        bytes_nxt = bytes_inc;
      end
    end else if (busy_r && (len == 4'd0)) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      held_r  <= '0;
      cnt_r   <= '0;
      bytes_r <= '0;
      busy_r  <= 1'b0;
    end else begin
      buf_r   <= buf_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
      bytes_r <= bytes_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

>>> test/tb_prefix_code_byte_decompressor_core.sv
// Self-checking testbench for prefix_code_byte_decompressor_core.
// Drives compressed bytes, predicts every decoded beat in a local decoder and checks them in order.
// Depends on pcbd_pkg and the RTL of the decompressor core only.
`timescale 1ns / 1ps

module tb_prefix_code_byte_decompressor_core;
  import pcbd_pkg::*;

  // Cycles to let pass after the last expected beat before the block counts as idle.
  // An input byte that completes no symbol still occupies the decoder after the
  // last beat, and up to two such bytes may sit in the input queue.
  localparam int QUIET_CYCLES = 32;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [BYTE_W-1:0]    in_byte = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_frame_end;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DICTIONARY;
  logic [DICT_W-1:0]    cfg_data = '0;

  prefix_code_byte_decompressor_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_byte      (in_byte),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte     (out_byte),
    .out_frame_end(out_frame_end),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Local decoder: its own copy of the registers and of the bit buffer state.
  // Every accepted input byte is decoded here at once and the beats it must
  // produce are appended to pending_beats, oldest first.
  // ---------------------------------------------------------------------------
  logic [DICT_W-1:0] dict_m;
  logic [FLEN_W-1:0] frame_len_m;
  logic [16:0]       bits_m;      // undecoded bits, oldest bit highest
  int unsigned       held_m;      // number of valid bits in bits_m
  logic [FLEN_W-1:0] count_m;     // bytes decoded so far in this frame

  result_t pending_beats[$];
  int      mismatch_count = 0;

  function automatic logic [7:0] peek_bits(int unsigned skip, int unsigned n);
    logic [31:0] w;
    w = {15'd0, bits_m};
    return 8'((w >> (held_m - skip - n)) & ((32'd1 << n) - 32'd1));
  endfunction

  function automatic void drop_bits(int unsigned n);
    held_m = held_m - n;
    bits_m = bits_m & 17'((32'd1 << held_m) - 32'd1);
  endfunction

  // Append one input byte to the buffer and decode every whole symbol in it, at
  // most eight. A completed frame discards whatever bits are still buffered,
  // the rest of the current input byte included.
  task automatic decode_byte(input logic [7:0] b);
    int          n;
    logic [7:0]  val;
    bit          done;
    int unsigned idx;
    result_t     beat;
    n = 0;
    if (held_m > 9) begin
      bits_m = '0;
      held_m = 0;
    end
    bits_m = {bits_m[8:0], b};
    held_m = held_m + 8;
    while (n < 8 && held_m >= 1) begin
      if (peek_bits(0, 1) == 8'd0) begin
        val = 8'h00;
        drop_bits(1);
      end else if (held_m < 2) begin
        break;
      end else if (peek_bits(1, 1) == 8'd1) begin
        // Literal: 11 followed by eight data bits.
        if (held_m < 10) break;
        val = peek_bits(2, 8);
        drop_bits(10);
      end else begin
        // 101 selects a dictionary entry, 100 a byte with one bit set.
        if (held_m < 6) break;
        idx = peek_bits(3, 3);
        if (peek_bits(2, 1) == 8'd1) val = dict_m[8*idx +: 8];
        else val = 8'd1 << idx;
        drop_bits(6);
      end
      count_m = count_m + 16'd1;
      done = (count_m == frame_len_m);
      beat.out_byte = val;
      beat.frame_end = done;
      beat.last = 1'b0;
      pending_beats = {pending_beats, beat};
      n++;
      if (done) begin
        bits_m = '0;
        held_m = 0;
        count_m = '0;
        break;
      end
    end
    if (n > 0) begin
      beat = pending_beats.pop_back();
      beat.last = 1'b1;
      pending_beats = {pending_beats, beat};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the pop pattern changes between stretches of always popping,
  // popping at random and stalling for long runs. Beats are checked at the
  // rising edge at which they are taken.
  // ---------------------------------------------------------------------------
  int pop_mode = 0;
  int pop_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (pop_left == 0) begin
        pop_mode = $urandom_range(0, 2);
        pop_left = $urandom_range(5, 40);
      end
      pop_left--;
      case (pop_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        default: out_pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < 40)
      $display("%0t: %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing pending", out_byte, 8'h00);
      end else begin
        want = pending_beats.pop_front();
        if (out_byte !== want.out_byte)
          report_mismatch("out_byte", out_byte, want.out_byte);
        if (out_frame_end !== want.frame_end)
          report_mismatch("out_frame_end", 8'(out_frame_end), 8'(want.frame_end));
        if (out_last !== want.last)
          report_mismatch("out_last", 8'(out_last), 8'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: bytes go out in bursts of random length with random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_push <= 1'b1;
    in_byte <= b;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    decode_byte(b);
  endtask

  // Stop sending and wait until every expected beat has arrived and the
  // decoder has had time to finish any byte that yields nothing.
  task automatic wait_quiet();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle; the write takes effect at once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DICT_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_DICTIONARY) dict_m = data;
    else if (idx == REG_FRAME_LENGTH) frame_len_m = data[FLEN_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: an empty dictionary and eight bytes per frame. Covers a byte
  // of eight zero symbols, a byte that completes nothing, a literal split over
  // two bytes and a single-bit symbol.
  task automatic test_reset_values();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hA0);
    send_byte(8'h9C);
    send_byte(8'h7F);
    send_byte(8'h80);
    wait_quiet();
  endtask

  // Every symbol kind against a patterned dictionary, with symbols that
  // straddle byte boundaries and a lone leading one left waiting.
  task automatic test_symbol_kinds();
    write_reg(REG_DICTIONARY, 64'h8877_6655_4433_2211);
    write_reg(REG_FRAME_LENGTH, 16'd65535);
    send_byte(8'hA4);
    send_byte(8'hBC);
    send_byte(8'h90);
    send_byte(8'h84);
    send_byte(8'hC3);
    send_byte(8'h5A);
    send_byte(8'h01);
    send_byte(8'hC0);
    send_byte(8'hB6);
    wait_quiet();
  endtask

  // Frame length at its extremes: one byte per frame drops the rest of each
  // input byte; zero stands for 65536 and ends no frame here.
  task automatic test_frame_extremes();
    write_reg(REG_DICTIONARY, {DICT_W{1'b1}});
    write_reg(REG_FRAME_LENGTH, 16'd1);
    send_byte(8'hFF);
    send_byte(8'h3C);
    send_byte(8'hB4);
    send_byte(8'h00);
    wait_quiet();
    write_reg(REG_FRAME_LENGTH, 16'd0);
    send_byte(8'h00);
    send_byte(8'hB4);
    send_byte(8'h55);
    wait_quiet();
  endtask

  // Frame length lowered below the count mid-frame: the count runs on past
  // it without ending the frame. Raising the length just above the count
  // afterwards closes the frame after two more zero symbols.
  task automatic test_frame_wrap();
    write_reg(REG_FRAME_LENGTH, 16'd1);
    send_byte(8'h00);
    wait_quiet();
    write_reg(REG_FRAME_LENGTH, 16'd20);
    send_byte(8'h00);
    send_byte(8'h00);
    wait_quiet();
    write_reg(REG_FRAME_LENGTH, 16'd5);
    repeat (30) send_byte(8'h00);
    send_byte(8'hC7);
    send_byte(8'hE1);
    wait_quiet();
    write_reg(REG_FRAME_LENGTH, count_m + 16'd2);
    send_byte(8'h00);
    wait_quiet();
  endtask

  // Random bytes, biased toward zero runs, all-ones and symbol headers, over
  // several register settings.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return {3'b101, 5'($urandom)};
      3: return {3'b100, 5'($urandom)};
      4: return {1'b0, 3'b110, 4'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_random();
    logic [FLEN_W-1:0] len;
    logic [DICT_W-1:0] dict;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin dict = {$urandom, $urandom}; len = 16'($urandom_range(2, 40)); end
        1: begin dict = '0; len = 16'd1; end
        2: begin dict = {$urandom, $urandom}; len = 16'd65535; end
        3: begin dict = {DICT_W{1'b1}}; len = 16'($urandom_range(2, 16)); end
        default: begin dict = {$urandom, $urandom}; len = FRAME_LENGTH_RESET; end
      endcase
      write_reg(REG_DICTIONARY, dict);
      write_reg(REG_FRAME_LENGTH, len);
      repeat (72) send_byte(pick_byte());
      wait_quiet();
    end
  endtask

  initial begin
    dict_m = '0;
    frame_len_m = FRAME_LENGTH_RESET;
    bits_m = '0;
    held_m = 0;
    count_m = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_symbol_kinds();
    test_frame_extremes();
    test_frame_wrap();
    test_random();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
